### rtl/bta_pkg.sv
package bta_pkg;

   // results per input character, at most this many
   localparam int BTA_MAX_RESULTS = 4;
   localparam int BTA_COUNT_W     = $clog2(BTA_MAX_RESULTS + 1);
   localparam int BTA_QUEUE_DEPTH = 2;

   // result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // characters of interest
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_X_LOWER   = 8'h78;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_A_LOWER   = 8'h61;
   localparam logic [7:0] CH_F_LOWER   = 8'h66;
   localparam logic [7:0] CH_A_UPPER   = 8'h41;
   localparam logic [7:0] CH_F_UPPER   = 8'h46;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0d;
   localparam logic [3:0] NIB_TEN      = 4'd10;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SPACE   = 2'd1,
      ST_INVALID = 2'd2,
      ST_TRUNC   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] data_byte;
      status_type status;
      logic       last_out;
   } rsp_type;

   // one result without its position flag
   typedef struct packed {
      logic       out_kind;
      logic [7:0] data_byte;
      status_type status;
   } res_type;

   // everything one input character produces, handed from front to back
   typedef struct packed {
      logic [BTA_COUNT_W-1:0]          count;
      res_type [BTA_MAX_RESULTS-1:0]   res;
   } work_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

### rtl/bta_front.sv
module bta_front
   import bta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req_data,
   output logic     work_push,
   output work_type work
);

   typedef enum logic [4:0] {
      PH_START    = 5'b00001,
      PH_START_BS = 5'b00010,
      PH_HEX      = 5'b00100,
      PH_OCT      = 5'b01000,
      PH_OCT_ESC  = 5'b10000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_chars_ff [2];
   logic [7:0] held_chars_in [2];
   logic [1:0] held_count_ff, held_count_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic       pair_open_ff, pair_open_in;
   status_type error_code_ff, error_code_in;

   // classify the character, update field state and collect its results
   always_comb begin
      logic [7:0]             c;
      logic [BTA_COUNT_W-1:0] cnt;
      res_type [BTA_MAX_RESULTS-1:0] res;
      logic [3:0]             nib;
      logic                   nib_ok;
      logic [9:0]             oct_val;
      status_type             st;

      c   = req_data.char_in;
      cnt = '0;
      res = '0;
      st  = ST_OK;
      phase_in       = phase_ff;
      held_chars_in  = held_chars_ff;
      held_count_in  = held_count_ff;
      high_nibble_in = high_nibble_ff;
      pair_open_in   = pair_open_ff;
      error_code_in  = error_code_ff;

      // hex digit value
      nib    = 4'd0;
      nib_ok = 1'b1;
      if (is_digit(c)) begin
         nib = 4'(c - CH_ZERO);
      end else if ((c >= CH_A_LOWER) && (c <= CH_F_LOWER)) begin
         nib = 4'(c - CH_A_LOWER) + NIB_TEN;
      end else if ((c >= CH_A_UPPER) && (c <= CH_F_UPPER)) begin
         nib = 4'(c - CH_A_UPPER) + NIB_TEN;
      end else begin
         nib_ok = 1'b0;
      end

      // three octal digits, kept modulo 256
      oct_val = ({6'd0, 4'(held_chars_ff[0] - CH_ZERO)} << 6)
              | ({6'd0, 4'(held_chars_ff[1] - CH_ZERO)} << 3)
              | {6'd0, 4'(c - CH_ZERO)};

      case (phase_ff)
         PH_START_BS: begin
            if (c == CH_X_LOWER) begin
               phase_in      = PH_HEX;
               pair_open_in  = 1'b0;
               error_code_in = ST_OK;
            end else if (is_digit(c)) begin
               phase_in         = PH_OCT_ESC;
               held_chars_in[0] = c;
               held_count_in    = 2'd1;
            end else begin
               phase_in = PH_OCT;
               held_count_in = 2'd0;
               res[cnt[1:0]] = '{KIND_DATA, c, ST_OK};
               cnt = cnt + 1'b1;
            end
         end
         PH_HEX: begin
            if (error_code_ff == ST_OK) begin
               if (is_space(c)) begin
                  if (pair_open_ff) error_code_in = ST_SPACE;
               end else if (!nib_ok) begin
                  error_code_in = ST_INVALID;
               end else if (pair_open_ff) begin
                  res[cnt[1:0]] = '{KIND_DATA, {high_nibble_ff, nib}, ST_OK};
                  cnt = cnt + 1'b1;
                  pair_open_in = 1'b0;
               end else begin
                  high_nibble_in = nib;
                  pair_open_in   = 1'b1;
               end
            end
         end
         PH_OCT: begin
            if (c == CH_BACKSLASH) begin
               phase_in      = PH_OCT_ESC;
               held_count_in = 2'd0;
            end else begin
               res[cnt[1:0]] = '{KIND_DATA, c, ST_OK};
               cnt = cnt + 1'b1;
            end
         end
         PH_OCT_ESC: begin
            if (is_digit(c)) begin
               if (held_count_ff < 2'd2) begin
                  held_chars_in[held_count_ff[0]] = c;
                  held_count_in = held_count_ff + 2'd1;
               end else begin
                  res[cnt[1:0]] = '{KIND_DATA, oct_val[7:0], ST_OK};
                  cnt = cnt + 1'b1;
                  phase_in      = PH_OCT;
                  held_count_in = 2'd0;
               end
            end else if (held_count_ff == 2'd0) begin
               res[cnt[1:0]] = '{KIND_DATA, c, ST_OK};
               cnt = cnt + 1'b1;
               phase_in = PH_OCT;
            end else begin
               // short escape: digits go out literally, then c unless backslash
               res[cnt[1:0]] = '{KIND_DATA, held_chars_ff[0], ST_OK};
               cnt = cnt + 1'b1;
               if (held_count_ff == 2'd2) begin
                  res[cnt[1:0]] = '{KIND_DATA, held_chars_ff[1], ST_OK};
                  cnt = cnt + 1'b1;
               end
               held_count_in = 2'd0;
               if (c == CH_BACKSLASH) begin
                  phase_in = PH_OCT_ESC;
               end else begin
                  phase_in = PH_OCT;
                  res[cnt[1:0]] = '{KIND_DATA, c, ST_OK};
                  cnt = cnt + 1'b1;
               end
            end
         end
         default: begin
            // field start, also for codes that mean nothing
            if (c == CH_BACKSLASH) begin
               phase_in = PH_START_BS;
            end else begin
               phase_in = PH_OCT;
               res[cnt[1:0]] = '{KIND_DATA, c, ST_OK};
               cnt = cnt + 1'b1;
            end
         end
      endcase

      // end of field: flush, append the end marker, return to reset values
      if (req_data.last_char) begin
         if (phase_in == PH_HEX) begin
            st = error_code_in;
            if ((st == ST_OK) && pair_open_in) st = ST_TRUNC;
         end else if (phase_in == PH_OCT_ESC) begin
            if (held_count_in >= 2'd1) begin
               res[cnt[1:0]] = '{KIND_DATA, held_chars_in[0], ST_OK};
               cnt = cnt + 1'b1;
            end
            if (held_count_in >= 2'd2) begin
               res[cnt[1:0]] = '{KIND_DATA, held_chars_in[1], ST_OK};
               cnt = cnt + 1'b1;
            end
         end
         res[cnt[1:0]] = '{KIND_END, 8'd0, st};
         cnt = cnt + 1'b1;
         phase_in       = PH_START;
         held_count_in  = 2'd0;
         high_nibble_in = 4'd0;
         pair_open_in   = 1'b0;
         error_code_in  = ST_OK;
      end

      work.count = cnt;
      work.res   = res;
   end

   assign work_push = accept && (work.count != '0);

   // field state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         held_count_ff  <= 2'd0;
         high_nibble_ff <= 4'd0;
         pair_open_ff   <= 1'b0;
         error_code_ff  <= ST_OK;
      end else if (accept) begin
         phase_ff       <= phase_in;
         held_count_ff  <= held_count_in;
         high_nibble_ff <= high_nibble_in;
         pair_open_ff   <= pair_open_in;
         error_code_ff  <= error_code_in;
      end
   end

   // held octal digits
   always_ff @(posedge clock) begin
      if (accept) begin
         held_chars_ff <= held_chars_in;
      end
   end

endmodule

### rtl/bta_queue.sv
module bta_queue
   import bta_pkg::*;
#(
   parameter int DEPTH = BTA_QUEUE_DEPTH
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output work_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   work_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == FULL_CNT);
   assign not_empty = (fill_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/bta_back.sv
module bta_back
   import bta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  work_type head,
   input  logic     rsp_pop,
   output logic     rsp_empty,
   output rsp_type  rsp_data,
   output logic     head_done
);

   localparam int IDX_W = $clog2(BTA_MAX_RESULTS);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             final_res;
   logic             take;

   // walk the results of the head entry one per transaction
   assign final_res = ({1'b0, idx_ff} + BTA_COUNT_W'(1)) == head.count;
   assign rsp_empty = !head_valid;
   assign take      = rsp_pop && head_valid;
   assign head_done = take && final_res;

   always_comb begin
      rsp_data.out_kind  = head.res[idx_ff].out_kind;
      rsp_data.data_byte = head.res[idx_ff].data_byte;
      rsp_data.status    = head.res[idx_ff].status;
      rsp_data.last_out  = final_res;
   end

   always_comb begin
      idx_in = idx_ff;
      if (head_done) begin
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### rtl/bytea_text_unescape.sv
// path: a character's results are registered in the work queue and reach the rsp ports once its entry is at the head
// throughput: one character per cycle; a character that yields n results holds the
//   result side for n rsp transactions, and req_full rises once the work queue (QUEUE_DEPTH) fills
// characters that yield no result are not queued but still wait while the queue is full
// reset: synchronous, active high; clears field state, queue pointers and result index
module bytea_text_unescape
   import bta_pkg::*;
#(
   parameter int QUEUE_DEPTH = BTA_QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic     accept;
   logic     work_push;
   work_type work;
   logic     q_full;
   logic     q_not_empty;
   work_type q_head;
   logic     q_pop;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // front: classify characters, track field state
   bta_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .work_push (work_push),
      .work      (work)
   );

   // work queue between front and back
   bta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // back: hand out results one transaction at a time
   bta_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_not_empty),
      .head       (q_head),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data),
      .head_done  (q_pop)
   );

   // a queued entry always carries at least one result
   assert property (@(posedge clock) disable iff (reset)
      work_push |-> (work.count != '0) && (work.count <= BTA_COUNT_W'(BTA_MAX_RESULTS)))
      else $error("work entry with bad result count");

   // a field's final character always ends with an end marker
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_char) |->
         work_push && (work.res[work.count[1:0] - 2'd1].out_kind == KIND_END))
      else $error("final character without end marker");

   // an end marker is always the final result of its character
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.out_kind == KIND_END)) |-> rsp_data.last_out)
      else $error("end marker not flagged as final result");

endmodule
